@@ hdl/urt_pkg.sv @@
// shared constants for the ultrasonic range timer
package urt_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_HIGH_PERIOD = 2'd0,
        CFG_LOW_PERIOD  = 2'd1
    } cfg_index_t;

    localparam int CFG_DATA_BITS = 16;
    localparam int PERIOD_BITS   = 16;

    // stamp width range and default
    localparam int STAMP_BITS_DEFAULT = 16;
    localparam int WIDE_BITS          = 32;

    // period reset values
    localparam logic [PERIOD_BITS-1:0] RESET_HIGH_PERIOD = 16'h0007;
    localparam logic [PERIOD_BITS-1:0] RESET_LOW_PERIOD  = 16'h927C;
    localparam logic [PERIOD_BITS-1:0] FIRST_PERIOD      = 16'hFFFF;

    // output widths
    localparam int FLIGHT_BITS = 16;
    localparam int RANGE_BITS  = 11;

    // range = floor((10*flight + 801) / 583) - 1, saturated
    localparam int  DIV_IN_BITS   = 21;
    localparam int  SMALL_BITS    = 17;
    localparam int  QUOT_BITS     = 12;
    localparam int  RECIP_SHIFT   = 30;
    localparam int  PROD_BITS     = 2 * DIV_IN_BITS;
    localparam logic [DIV_IN_BITS-1:0] SCALE_TENTHS  = 21'd10;
    localparam logic [DIV_IN_BITS-1:0] OFFSET_TENTHS = 21'd801;
    // ceil(2^30 / 583), exact for every dividend below 2^21
    localparam logic [DIV_IN_BITS-1:0] RECIP_MULT    = 21'd1841753;
    // smallest flight whose range is past the saturation point
    localparam logic [WIDE_BITS-1:0]   FLIGHT_SAT    = 32'd119377;
    localparam logic [QUOT_BITS-1:0]   RANGE_MAX     = 12'd2047;

    // record moved from the state stage to the range stage
    typedef struct packed {
        logic trigger;
        logic done;
    } slot_flags_t;

endpackage

@@ hdl/ultrasonic_range_timer.sv @@
// ultrasonic range timer: trigger pulse generator, echo capture and range conversion
//
// One request is taken every clock while in_stall is low; each request is one
// time slot carrying a trigger-timer tick, a microsecond tick and the echo pin
// level, and yields one result with the trigger level, the echo time of flight,
// the range and an echo-done flag. The pipeline has an input register, a stage
// that runs the period timer, microsecond counter and echo captures and forms
// the flight difference, and a stage that converts flight to range with one
// 21x21 reciprocal multiply. Each stage holds independently under stall, so a
// result waiting at the output does not block earlier stages that have room.
// Period register writes take effect at the next period match.
module ultrasonic_range_timer #(
    parameter int STAMP_BITS = urt_pkg::STAMP_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_write,
    input  logic [urt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [urt_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // slot requests
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               timer_tick,
    input  logic                               micro_tick,
    input  logic                               echo_level,
    // results
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               trigger_level,
    output logic [urt_pkg::FLIGHT_BITS-1:0]    flight_time_us,
    output logic [urt_pkg::RANGE_BITS-1:0]     range_value,
    output logic                               echo_done
);

    // configuration registers
    logic [urt_pkg::PERIOD_BITS-1:0] high_period_reg;
    logic [urt_pkg::PERIOD_BITS-1:0] low_period_reg;

    // pipeline control
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s2_free;
    logic s1_free;
    logic in_accept;
    logic s1_move;
    logic s2_move;

    // input register
    logic s1_tick_reg;
    logic s1_utick_reg;
    logic s1_echo_reg;

    // slot state
    logic [urt_pkg::PERIOD_BITS-1:0] period_count_reg;
    logic [urt_pkg::PERIOD_BITS-1:0] period_count_next;
    logic [urt_pkg::PERIOD_BITS-1:0] active_period_reg;
    logic [urt_pkg::PERIOD_BITS-1:0] active_period_next;
    logic                            pulse_phase_reg;
    logic                            pulse_phase_next;
    logic                            trigger_reg;
    logic                            trigger_next;
    logic [STAMP_BITS-1:0]           micro_count_reg;
    logic [STAMP_BITS-1:0]           micro_count_next;
    logic                            echo_prev_reg;
    logic [STAMP_BITS-1:0]           start_stamp_reg;
    logic [STAMP_BITS-1:0]           start_stamp_next;
    logic [STAMP_BITS-1:0]           end_stamp_reg;
    logic [STAMP_BITS-1:0]           end_stamp_next;
    logic                            done_next;

    // state stage output
    logic [STAMP_BITS-1:0]   s2_flight_reg;
    urt_pkg::slot_flags_t    s2_flags_reg;
    urt_pkg::slot_flags_t    s2_flags_next;

    // range stage
    logic [urt_pkg::WIDE_BITS-1:0]   flight_wide;
    logic [urt_pkg::DIV_IN_BITS-1:0] dividend;
    logic [urt_pkg::PROD_BITS-1:0]   product;
    logic [urt_pkg::QUOT_BITS-1:0]   quotient;
    logic [urt_pkg::QUOT_BITS-1:0]   range_wide;
    logic [urt_pkg::RANGE_BITS-1:0]  range_next;

    // output register
    logic                             trigger_out_reg;
    logic [urt_pkg::FLIGHT_BITS-1:0]  flight_out_reg;
    logic [urt_pkg::RANGE_BITS-1:0]   range_out_reg;
    logic                             done_out_reg;

    // stage handshakes: a stage takes new data when empty or when it drains
    assign out_free  = !out_valid_reg || !out_stall;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s1_free   = !s1_valid_reg || s2_free;
    assign in_stall  = !s1_free;
    assign in_accept = in_valid && s1_free;
    assign s1_move   = s1_valid_reg && s2_free;
    assign s2_move   = s2_valid_reg && out_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_period_reg <= urt_pkg::RESET_HIGH_PERIOD;
            low_period_reg  <= urt_pkg::RESET_LOW_PERIOD;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                urt_pkg::CFG_HIGH_PERIOD: high_period_reg <= cfg_data;
                urt_pkg::CFG_LOW_PERIOD:  low_period_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_accept || (s1_valid_reg && !s2_free);
            s2_valid_reg  <= s1_move || (s2_valid_reg && !out_free);
            out_valid_reg <= s2_move || (out_valid_reg && out_stall);
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_tick_reg  <= timer_tick;
            s1_utick_reg <= micro_tick;
            s1_echo_reg  <= echo_level;
        end
    end

    // echo captures, microsecond counter and period timer for one slot
    always_comb
    begin
        start_stamp_next   = start_stamp_reg;
        end_stamp_next     = end_stamp_reg;
        done_next          = 1'b0;
        micro_count_next   = micro_count_reg;
        period_count_next  = period_count_reg;
        active_period_next = active_period_reg;
        pulse_phase_next   = pulse_phase_reg;
        trigger_next       = trigger_reg;

        // captures see the count from before this slot's tick
        if (s1_echo_reg && !echo_prev_reg)
        begin
            start_stamp_next = micro_count_reg;
        end
        else if (!s1_echo_reg && echo_prev_reg)
        begin
            end_stamp_next = micro_count_reg;
            done_next      = 1'b1;
        end

        if (s1_utick_reg)
        begin
            micro_count_next = micro_count_reg + 1'b1;
        end

        // period match toggles the trigger and loads the other period
        if (s1_tick_reg)
        begin
            if (period_count_reg >= active_period_reg)
            begin
                period_count_next = '0;
                if (!pulse_phase_reg)
                begin
                    active_period_next = high_period_reg;
                    pulse_phase_next   = 1'b1;
                    trigger_next       = 1'b1;
                end
                else
                begin
                    active_period_next = low_period_reg;
                    pulse_phase_next   = 1'b0;
                    trigger_next       = 1'b0;
                end
            end
            else
            begin
                period_count_next = period_count_reg + 1'b1;
            end
        end

        s2_flags_next.trigger = trigger_next;
        s2_flags_next.done    = done_next;
    end

    // slot state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_count_reg  <= '0;
            active_period_reg <= urt_pkg::FIRST_PERIOD;
            pulse_phase_reg   <= 1'b0;
            trigger_reg       <= 1'b0;
            micro_count_reg   <= '0;
            echo_prev_reg     <= 1'b0;
            start_stamp_reg   <= '0;
            end_stamp_reg     <= '0;
        end
        else if (s1_move)
        begin
            period_count_reg  <= period_count_next;
            active_period_reg <= active_period_next;
            pulse_phase_reg   <= pulse_phase_next;
            trigger_reg       <= trigger_next;
            micro_count_reg   <= micro_count_next;
            echo_prev_reg     <= s1_echo_reg;
            start_stamp_reg   <= start_stamp_next;
            end_stamp_reg     <= end_stamp_next;
        end
    end

    // flight difference register
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_flight_reg <= end_stamp_next - start_stamp_next;
            s2_flags_reg  <= s2_flags_next;
        end
    end

    // range conversion by reciprocal multiply, saturated at both ends
    always_comb
    begin
        flight_wide = urt_pkg::WIDE_BITS'(s2_flight_reg);
        dividend    = {{(urt_pkg::DIV_IN_BITS - urt_pkg::SMALL_BITS){1'b0}},
                       flight_wide[urt_pkg::SMALL_BITS-1:0]} * urt_pkg::SCALE_TENTHS
                      + urt_pkg::OFFSET_TENTHS;
        product     = {{urt_pkg::DIV_IN_BITS{1'b0}}, dividend}
                      * {{urt_pkg::DIV_IN_BITS{1'b0}}, urt_pkg::RECIP_MULT};
        quotient    = product[urt_pkg::PROD_BITS-1:urt_pkg::RECIP_SHIFT];
        range_wide  = (quotient == '0) ? '0 : quotient - 1'b1;
        if (flight_wide >= urt_pkg::FLIGHT_SAT || range_wide > urt_pkg::RANGE_MAX)
        begin
            range_next = urt_pkg::RANGE_BITS'(urt_pkg::RANGE_MAX);
        end
        else
        begin
            range_next = range_wide[urt_pkg::RANGE_BITS-1:0];
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            trigger_out_reg <= s2_flags_reg.trigger;
            flight_out_reg  <= flight_wide[urt_pkg::FLIGHT_BITS-1:0];
            range_out_reg   <= range_next;
            done_out_reg    <= s2_flags_reg.done;
        end
    end

    assign out_valid      = out_valid_reg;
    assign trigger_level  = trigger_out_reg;
    assign flight_time_us = flight_out_reg;
    assign range_value    = range_out_reg;
    assign echo_done      = done_out_reg;

    // input stalls only when every stage is full and the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && s2_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipeline");

    // a held result keeps the state stage occupied
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && out_valid_reg && out_stall) |=> s2_valid_reg)
        else $error("state stage dropped a request under stall");

    // the period counter never runs past the active period
    assert property (@(posedge clk) disable iff (!rst_n)
        period_count_reg <= active_period_reg)
        else $error("period counter beyond active period");

    // trigger only changes when a slot is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        (trigger_reg != $past(trigger_reg)) |-> $past(s1_move))
        else $error("trigger changed without a slot");

endmodule
